// ===== hdl/ccdfc_pkg.sv =====
// Shared types and constants for the CCD frame calibration block.
`default_nettype none
package ccdfc_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_GAIN0   = 3'd0;
  localparam logic [2:0] REG_GAIN1   = 3'd1;
  localparam logic [2:0] REG_GAIN2   = 3'd2;
  localparam logic [2:0] REG_OFFSETS = 3'd3;
  localparam logic [2:0] REG_SIZES   = 3'd4;
  localparam logic [2:0] REG_MODE    = 3'd5;
  localparam logic [2:0] REG_MAXS    = 3'd6;

  // Mode register bits.
  localparam int MODE_DARK  = 0;
  localparam int MODE_FLAT  = 1;
  localparam int MODE_MULTI = 2;

  // Number of quotient bits produced by the lane divider.
  localparam int QUOT_BITS = 32;

  // Per-lane calibration settings.
  typedef struct packed {
    logic               dark_en;
    logic               flat_en;
    logic signed [31:0] gain;
    logic signed [19:0] off;
    logic [15:0]        maxv;
  } lane_cfg_t;

  // Crop window decision for the current input pixel.
  typedef struct packed {
    logic        keep;
    logic        last;
    logic [15:0] row;
    logic [15:0] col;
  } win_t;

  // Lane sequencer states.
  typedef enum logic [2:0] {
    LS_IDLE,
    LS_DIV,
    LS_SIGN,
    LS_MULLO,
    LS_MULHI,
    LS_SUM,
    LS_CLAMP,
    LS_DONE
  } lane_state_t;

endpackage
`default_nettype wire

// ===== hdl/ccd_frame_calibration_top.sv =====
// Top level of the CCD frame calibration block: registers, lanes and output merge.
//
//  Channel  Signals                    Direction  Content
//  s_*      s_tvalid/s_tready/s_tdata  in         raw, dark, flat samples of one pixel
//  m_*      m_tvalid/m_tready/m_tdata  out        calibrated pixel and its coordinates
//  cfg_*    cfg_we/cfg_index/cfg_data  in         register writes
//
// A kept pixel runs through the lane divider when flat divide is on (it makes one
// quotient bit per cycle over 32 bits), then sign, multiply, sum and clamp; a pixel outside
// the crop window is taken without starting the lanes. One pixel is in work at a time, all planes in parallel.
// Reset is synchronous and clears the registers to their defaults and the raster to 0.
// A finished result waits in the output register while the next pixel is taken; if
// that pixel finishes first, its lanes hold and s_tready stays low until m_tready.
`default_nettype none
module ccd_frame_calibration_top #(
  parameter int PLANES      = 3,
  parameter int SAMPLE_BITS = 16,
  parameter int DIM_BITS    = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // raw_plane0..2, dark_plane0..2, flat_plane0..2, 16 bits each, from bit 0 up
  input  wire logic [143:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // value_plane0, value_plane1, value_plane2, out_row, out_col, 16 bits each
  output logic [79:0]       m_tdata,
  output logic              m_tlast,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);
  import ccdfc_pkg::*;

  localparam logic [15:0] SMASK = 16'((32'd1 << SAMPLE_BITS) - 1);

  logic signed [31:0] gain [3];
  logic [59:0]        offsets;
  logic [63:0]        sizes;
  logic [2:0]         mode;
  logic [15:0]        max_s;

  logic        busy;
  logic        accept, load;
  logic [15:0] maxv;
  win_t        win;
  logic [15:0] row_r, col_r;
  logic        last_r;
  logic [2:0]  lane_done;
  logic [15:0] lane_val [3];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain[0] <= 32'sd65536;
      gain[1] <= 32'sd65536;
      gain[2] <= 32'sd65536;
      offsets <= '0;
      sizes   <= 64'd288234774265332736;
      mode    <= 3'd4;
      max_s   <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN0:   gain[0] <= cfg_data[31:0];
        REG_GAIN1:   gain[1] <= cfg_data[31:0];
        REG_GAIN2:   gain[2] <= cfg_data[31:0];
        REG_OFFSETS: offsets <= cfg_data[59:0];
        REG_SIZES:   sizes   <= cfg_data;
        REG_MODE:    mode    <= cfg_data[2:0];
        REG_MAXS:    max_s   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign maxv     = (max_s > SMASK) ? SMASK : max_s;
  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign load     = busy && (&lane_done) && (!m_tvalid || m_tready);

  ccdfc_window #(.DIM_BITS(DIM_BITS)) u_window (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .sizes   (sizes),
    .win     (win)
  );

  // One lane per built plane; planes not built report done with a zero value.
  for (genvar k = 0; k < 3; k++) begin : g_lane
    if (k < PLANES) begin : g_on
      lane_cfg_t lcfg;
      assign lcfg.dark_en = mode[MODE_DARK];
      assign lcfg.flat_en = mode[MODE_FLAT];
      assign lcfg.gain    = gain[k];
      assign lcfg.off     = offsets[20*k +: 20];
      assign lcfg.maxv    = maxv;
      ccdfc_lane u_lane (
        .clk   (clk),
        .rst   (rst),
        .start (accept && win.keep),
        .ack   (load),
        .cfg   (lcfg),
        .raw   (s_tdata[16*k +: 16] & SMASK),
        .dark  (s_tdata[16*(k+3) +: 16] & SMASK),
        .flat  (s_tdata[16*(k+6) +: 16] & SMASK),
        .done  (lane_done[k]),
        .value (lane_val[k])
      );
    end else begin : g_off
      assign lane_done[k] = 1'b1;
      assign lane_val[k]  = 16'd0;
    end
  end

  // Busy flag and coordinates of the pixel in work.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept && win.keep) begin
      busy <= 1'b1;
    end else if (load) begin
      busy <= 1'b0;
    end
    if (accept && win.keep) begin
      row_r  <= win.row;
      col_r  <= win.col;
      last_r <= win.last;
    end
  end

  // Output register merges the lanes; extra planes read zero in single-plane mode.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (load) begin
      m_tdata <= {col_r, row_r,
                  mode[MODE_MULTI] ? lane_val[2] : 16'd0,
                  mode[MODE_MULTI] ? lane_val[1] : 16'd0,
                  lane_val[0]};
      m_tlast <= last_r;
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    accept && win.keep |=> busy) else $error("kept pixel did not start lanes");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    lane_done[0] |-> busy) else $error("lane finished with no pixel in work");
  a_out_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(busy)) else $error("result appeared with no pixel in work");

endmodule
`default_nettype wire

// ===== hdl/ccdfc_lane.sv =====
// One calibration lane: dark subtract, flat divide, gain, offset, round and clamp.
`default_nettype none
module ccdfc_lane (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic                ack,
  input  wire ccdfc_pkg::lane_cfg_t cfg,
  input  wire logic [15:0]         raw,
  input  wire logic [15:0]         dark,
  input  wire logic [15:0]         flat,
  output logic                     done,
  output logic [15:0]              value
);
  import ccdfc_pkg::*;

  lane_state_t state, state_next;

  logic [4:0]          step;
  logic [15:0]         flat_r;
  logic                neg;
  logic                pos;
  logic                zflat;
  logic [15:0]         rem;
  logic [31:0]         qd;
  logic signed [32:0]  q;
  logic signed [49:0]  plo;
  logic signed [47:0]  phi;
  logic signed [34:0]  v;

  logic signed [16:0]  d;
  logic [15:0]         mag;
  logic [16:0]         trial;
  logic                ge;
  logic signed [17:0]  mop;
  logic signed [49:0]  prod;
  logic signed [66:0]  total;

  // Difference and its magnitude.
  always_comb begin
    d     = $signed({1'b0, raw}) - (cfg.dark_en ? $signed({1'b0, dark}) : 17'sd0);
    mag   = d[16] ? 16'(-d) : d[15:0];
    trial = {rem, qd[31]};
    ge    = trial >= {1'b0, flat_r};
    mop   = (state == LS_MULLO) ? $signed({1'b0, q[16:0]}) : 18'($signed(q[32:17]));
    prod  = 50'(cfg.gain) * 50'(mop);
    total = (67'(phi) <<< 17) + 67'(plo) + (67'(cfg.off) <<< 30) + (67'sd1 <<< 31);
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and done flag.
  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      LS_IDLE:  if (start) state_next = cfg.flat_en ? LS_DIV : LS_SIGN;
      LS_DIV:   if (step == 5'(QUOT_BITS - 1)) state_next = LS_SIGN;
      LS_SIGN:  state_next = LS_MULLO;
      LS_MULLO: state_next = LS_MULHI;
      LS_MULHI: state_next = LS_SUM;
      LS_SUM:   state_next = LS_CLAMP;
      LS_CLAMP: state_next = LS_DONE;
      LS_DONE: begin
        done = 1'b1;
        if (ack) state_next = LS_IDLE;
      end
      default:  state_next = LS_IDLE;
    endcase
  end

  // Datapath: restoring divider one bit a cycle, then a shared 32x18 multiplier.
  always_ff @(posedge clk) begin
    case (state)
      LS_IDLE: begin
        neg    <= d[16];
        pos    <= !d[16] && (mag != 16'd0);
        zflat  <= cfg.flat_en && (flat == 16'd0);
        flat_r <= flat;
        rem    <= 16'd0;
        step   <= 5'd0;
        qd     <= {mag, 16'd0};
      end
      LS_DIV: begin
        rem  <= ge ? 16'(trial - {1'b0, flat_r}) : trial[15:0];
        qd   <= {qd[30:0], ge};
        step <= step + 5'd1;
      end
      LS_SIGN:  q   <= neg ? -$signed({1'b0, qd}) : $signed({1'b0, qd});
      LS_MULLO: plo <= prod;
      LS_MULHI: phi <= prod[47:0];
      LS_SUM:   v   <= total[66:32];
      LS_CLAMP: begin
        if (zflat) begin
          value <= pos ? cfg.maxv : 16'd0;
        end else if (v < 35'sd0) begin
          value <= 16'd0;
        end else if (v > $signed({19'd0, cfg.maxv})) begin
          value <= cfg.maxv;
        end else begin
          value <= v[15:0];
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/ccdfc_window.sv =====
// Input raster counters and centred crop window with output coordinates.
`default_nettype none
module ccdfc_window #(
  parameter int DIM_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire logic [63:0] sizes,
  output ccdfc_pkg::win_t  win
);
  import ccdfc_pkg::*;

  localparam logic [15:0] DMASK = 16'((32'd1 << DIM_BITS) - 1);

  logic [DIM_BITS-1:0] col, row;

  logic [16:0] in_w, in_h, ow, oh, cskip, rskip, cmarg, rmarg, cend, rend, colx, rowx;

  // Window geometry from the frame size register.
  always_comb begin
    in_w  = {1'b0, sizes[15:0] & DMASK};
    in_h  = {1'b0, sizes[31:16] & DMASK};
    ow    = {1'b0, sizes[47:32] & DMASK};
    oh    = {1'b0, sizes[63:48] & DMASK};
    if (ow == 17'd0) ow = in_w;
    if (oh == 17'd0) oh = in_h;
    cskip = (ow < in_w) ? ((in_w - ow) >> 1) : 17'd0;
    rskip = (oh < in_h) ? ((in_h - oh) >> 1) : 17'd0;
    cmarg = (ow > in_w) ? ((ow - in_w) >> 1) : 17'd0;
    rmarg = (oh > in_h) ? ((oh - in_h) >> 1) : 17'd0;
    cend  = cskip + ((ow < in_w) ? ow : in_w);
    rend  = rskip + ((oh < in_h) ? oh : in_h);
    colx  = 17'(col);
    rowx  = 17'(row);
    win.keep = (colx >= cskip) && (colx < cend) && (rowx >= rskip) && (rowx < rend);
    win.last = (colx == cend - 17'd1) && (rowx == rend - 17'd1);
    win.col  = 16'(cmarg + colx - cskip);
    win.row  = 16'(rmarg + rowx - rskip);
  end

  // Raster counters advance on every input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (advance) begin
      if (colx + 17'd1 >= in_w) begin
        col <= '0;
        row <= (rowx + 17'd1 >= in_h) ? '0 : DIM_BITS'(rowx + 17'd1);
      end else begin
        col <= DIM_BITS'(colx + 17'd1);
      end
    end
  end

endmodule
`default_nettype wire
